/* rtl/core/hcf_pkg.sv */
// Shared constants, types and helper functions for the Harris corner flag stream.
package hcf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RING_ROWS      = 8;
    localparam int RING_BITS      = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 11'd480;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int GRAD_W  = 12;
    localparam int SHAPE_W = 8;
    localparam int MOM_W   = 18;
    localparam int OP_W    = 19;
    localparam int PROD_W  = 38;
    localparam int CMP_W   = 43;

    typedef struct packed {
        logic [MOM_W-1:0] sxx;
        logic [MOM_W-1:0] sxy;
        logic [MOM_W-1:0] syy;
    } mom_sums_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOM,
        ST_RESP,
        ST_PUT
    } top_state_t;

    typedef enum logic [2:0] {
        RS_IDLE,
        RS_P1,
        RS_P2,
        RS_P3,
        RS_SUM,
        RS_CMP
    } resp_state_t;

    function automatic logic signed [2:0] coef_x(input logic [1:0] a, input logic [1:0] b);
        logic signed [2:0] m;
        begin
            m = (a == 2'd1) ? 3'sd2 : 3'sd1;
            case (b)
                2'd0:    coef_x = -m;
                2'd2:    coef_x = m;
                default: coef_x = 3'sd0;
            endcase
        end
    endfunction

    function automatic logic signed [2:0] coef_y(input logic [1:0] a, input logic [1:0] b);
        logic signed [2:0] m;
        begin
            m = (b == 2'd1) ? 3'sd2 : 3'sd1;
            case (a)
                2'd0:    coef_y = m;
                2'd2:    coef_y = -m;
                default: coef_y = 3'sd0;
            endcase
        end
    endfunction

    function automatic logic [SHAPE_W-1:0] shape_grad(input logic signed [GRAD_W-1:0] v);
        logic signed [GRAD_W-1:0] lo;
        logic signed [GRAD_W-1:0] hi;
        logic signed [GRAD_W-1:0] d;
        begin
            lo = GRAD_W'(127);
            hi = GRAD_W'(255);
            d  = v - lo;
            if (v <= lo)
                shape_grad = '0;
            else if (v >= hi)
                shape_grad = SHAPE_W'(128);
            else
                shape_grad = d[SHAPE_W-1:0];
        end
    endfunction

endpackage

/* rtl/core/hcf_if.sv */
// Channel interfaces: pixel input, corner result output and configuration write.
interface hcf_in_if;
    import hcf_pkg::*;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] pixel;
    modport source(output valid, req_type, pixel, input ready);
    modport sink(input valid, req_type, pixel, output ready);
endinterface

interface hcf_out_if;
    import hcf_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               corner;
    logic               frame_end;
    modport source(output valid, col, row, corner, frame_end, input ready);
    modport sink(input valid, col, row, corner, frame_end, output ready);
endinterface

interface hcf_cfg_if;
    import hcf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/hcf_ram.sv */
// Generic simple dual-port RAM with registered read.
module hcf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/hcf_moments.sv */
// Gradient sequencer: reads pixel neighborhoods, forms Sobel gradients, sums moments.
module hcf_moments #(
    parameter int MAX_WIDTH  = hcf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hcf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 start,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]                       anchor_col,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]                      anchor_row,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]                       width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]                      height,
    output logic                                                 rd_en,
    output logic [hcf_pkg::RING_BITS+$clog2(MAX_WIDTH)-1:0]      rd_addr,
    input  logic [hcf_pkg::PIX_W-1:0]                            rd_data,
    output logic                                                 done,
    output hcf_pkg::mom_sums_t                                   sums
);
    import hcf_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int COLA = $clog2(MAX_WIDTH);

    logic             run_reg;
    logic [1:0]       gi_reg, gj_reg, ni_reg, nj_reg;
    logic [RW:0]      u_row, p_row;
    logic [CW:0]      u_col, p_col;
    logic             oob;
    logic             nb_last, g_last;

    logic             s1_valid_reg, s1_oob_reg, s1_first_reg, s1_last_reg, s1_final_reg;
    logic [1:0]       s1_ni_reg, s1_nj_reg;
    logic [PIX_W-1:0] pix;
    logic signed [GRAD_W-1:0] cx, cy, gx_sum, gy_sum;
    logic signed [GRAD_W-1:0] gx_acc_reg, gy_acc_reg;

    logic               s2_valid_reg, s2_final_reg;
    logic [SHAPE_W-1:0] gxs_reg, gys_reg;
    logic               done_reg;
    mom_sums_t          sums_reg;

    assign u_row = (RW+1)'(anchor_row) + (RW+1)'(gi_reg) + (RW+1)'(ni_reg);
    assign u_col = (CW+1)'(anchor_col) + (CW+1)'(gj_reg) + (CW+1)'(nj_reg);
    assign p_row = u_row - (RW+1)'(1);
    assign p_col = u_col - (CW+1)'(1);
    assign oob   = (u_row == '0) || (u_row > {1'b0, height})
                || (u_col == '0) || (u_col > {1'b0, width});

    assign rd_en   = run_reg && !oob;
    assign rd_addr = {p_row[RING_BITS-1:0], p_col[COLA-1:0]};

    assign nb_last = (ni_reg == 2'd2) && (nj_reg == 2'd2);
    assign g_last  = (gi_reg == 2'd2) && (gj_reg == 2'd2);

    assign pix    = s1_oob_reg ? '0 : rd_data;
    assign cx     = GRAD_W'(coef_x(s1_ni_reg, s1_nj_reg)) * GRAD_W'($signed({1'b0, pix}));
    assign cy     = GRAD_W'(coef_y(s1_ni_reg, s1_nj_reg)) * GRAD_W'($signed({1'b0, pix}));
    assign gx_sum = (s1_first_reg ? '0 : gx_acc_reg) + cx;
    assign gy_sum = (s1_first_reg ? '0 : gy_acc_reg) + cy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= run_reg;
            s2_valid_reg <= s1_valid_reg && s1_last_reg;
            done_reg     <= s2_valid_reg && s2_final_reg;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && nb_last && g_last)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            gi_reg   <= '0;
            gj_reg   <= '0;
            ni_reg   <= '0;
            nj_reg   <= '0;
            sums_reg <= '0;
        end
        else
        begin
            if (run_reg)
            begin
                nj_reg <= (nj_reg == 2'd2) ? 2'd0 : nj_reg + 2'd1;
                if (nj_reg == 2'd2)
                begin
                    ni_reg <= (ni_reg == 2'd2) ? 2'd0 : ni_reg + 2'd1;
                end
                if (nb_last)
                begin
                    gj_reg <= (gj_reg == 2'd2) ? 2'd0 : gj_reg + 2'd1;
                    if (gj_reg == 2'd2)
                    begin
                        gi_reg <= gi_reg + 2'd1;
                    end
                end
            end
            if (s2_valid_reg)
            begin
                sums_reg.sxx <= sums_reg.sxx + MOM_W'(gxs_reg) * MOM_W'(gxs_reg);
                sums_reg.sxy <= sums_reg.sxy + MOM_W'(gxs_reg) * MOM_W'(gys_reg);
                sums_reg.syy <= sums_reg.syy + MOM_W'(gys_reg) * MOM_W'(gys_reg);
            end
        end
        s1_oob_reg   <= oob;
        s1_ni_reg    <= ni_reg;
        s1_nj_reg    <= nj_reg;
        s1_first_reg <= (ni_reg == 2'd0) && (nj_reg == 2'd0);
        s1_last_reg  <= nb_last;
        s1_final_reg <= nb_last && g_last;
        if (s1_valid_reg)
        begin
            gx_acc_reg <= gx_sum;
            gy_acc_reg <= gy_sum;
        end
        gxs_reg      <= shape_grad(gx_sum);
        gys_reg      <= shape_grad(gy_sum);
        s2_final_reg <= s1_final_reg;
    end

    assign done = done_reg;
    assign sums = sums_reg;

endmodule

/* rtl/core/hcf_resp.sv */
// Harris response test: 25*det > trace^2 with one shared multiplier used in turn for each product.
module hcf_resp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  hcf_pkg::mom_sums_t sums,
    output logic               done,
    output logic               corner
);
    import hcf_pkg::*;

    resp_state_t state_reg, state_next;
    logic [OP_W-1:0]   op_a_reg, op_b_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CMP_W-1:0]  lhs_reg, rhs_reg;
    logic [CMP_W-1:0]  prod25;
    logic [OP_W-1:0]   trace;

    assign trace  = OP_W'(sums.sxx) + OP_W'(sums.syy);
    assign prod25 = (CMP_W'(prod_reg) << 4) + (CMP_W'(prod_reg) << 3) + CMP_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        corner     = lhs_reg > rhs_reg;
        case (state_reg)
            RS_IDLE:
            begin
                if (start)
                begin
                    state_next = RS_P1;
                end
            end
            RS_P1:  state_next = RS_P2;
            RS_P2:  state_next = RS_P3;
            RS_P3:  state_next = RS_SUM;
            RS_SUM: state_next = RS_CMP;
            RS_CMP:
            begin
                done       = 1'b1;
                state_next = RS_IDLE;
            end
            default: state_next = RS_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a_reg) * PROD_W'(op_b_reg);
        case (state_reg)
            RS_IDLE:
            begin
                op_a_reg <= OP_W'(sums.sxx);
                op_b_reg <= OP_W'(sums.syy);
            end
            RS_P1:
            begin
                op_a_reg <= OP_W'(sums.sxy);
                op_b_reg <= OP_W'(sums.sxy);
            end
            RS_P2:
            begin
                lhs_reg  <= prod25;
                op_a_reg <= trace;
                op_b_reg <= trace;
            end
            RS_P3:
            begin
                rhs_reg <= prod25;
            end
            RS_SUM:
            begin
                rhs_reg <= rhs_reg + CMP_W'(prod_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/core/harris_corner_flag_stream.sv */
// Top level of the Harris corner flag stream: frame counters, control sequencer, result register.
// Pixels arrive in raster order into an eight-row line ring held in one RAM; each anchor is
// evaluated once the pixels it needs have arrived. An item that releases no result passes
// through the accept and check states only; an item that releases one also runs the 81 positions
// of the 3x3 neighborhoods of the 3x3 gradient window through the single RAM read port (positions
// outside the image are not read), then the gradient and moment pipeline registers, the response
// multiplier sequence and the put state. A finished result waits in the output register while
// the next item is taken; a result that finds the register still occupied holds until the
// register drains. Writing either size register restarts the frame; sizes are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT.
module harris_corner_flag_stream #(
    parameter int MAX_WIDTH  = hcf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hcf_pkg::DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    hcf_in_if.sink      pix_in,
    hcf_out_if.source   res_out,
    hcf_cfg_if.sink     cfg
);
    import hcf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int COLA  = $clog2(MAX_WIDTH);
    localparam int DEPTH = RING_ROWS << COLA;
    localparam int AW    = $clog2(DEPTH);

    top_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] width_cfg_reg, height_cfg_reg;
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [RW-1:0] in_row_reg, out_row_reg;

    logic in_take, cfg_take, out_free;
    logic mom_start, resp_start, put;
    logic pix_write;

    logic [RW:0] y3, hm1, nr;
    logic [CW:0] x3, wm1, nc;
    logic        seen, anchor_ready, last;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [PIX_W-1:0] rd_data;
    logic             mom_done, resp_done, resp_corner;
    mom_sums_t        sums;
    logic             corner_res_reg;

    logic               out_valid_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic               corner_reg, frame_end_reg;

    always_comb
    begin
        if (width_cfg_reg < CFG_DATA_W'(3))
            w_eff = CW'(3);
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_cfg_reg);
        if (height_cfg_reg < CFG_DATA_W'(3))
            h_eff = RW'(3);
        else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT))
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(height_cfg_reg);
    end

    assign in_take   = pix_in.valid && pix_in.ready;
    assign cfg_take  = cfg.valid && cfg.ready;
    assign out_free  = !out_valid_reg || res_out.ready;
    assign pix_write = in_take && (pix_in.req_type == REQ_PIXEL) && (in_row_reg < h_eff);

    assign y3   = (RW+1)'(out_row_reg) + (RW+1)'(3);
    assign hm1  = (RW+1)'(h_eff) - (RW+1)'(1);
    assign nr   = (y3 < hm1) ? y3 : hm1;
    assign x3   = (CW+1)'(out_col_reg) + (CW+1)'(3);
    assign wm1  = (CW+1)'(w_eff) - (CW+1)'(1);
    assign nc   = (x3 < wm1) ? x3 : wm1;
    assign seen = (nr < (RW+1)'(in_row_reg))
               || ((nr == (RW+1)'(in_row_reg)) && (nc < (CW+1)'(in_col_reg)));
    assign anchor_ready = (in_row_reg >= h_eff) || seen;
    assign last = ((RW+1)'(out_row_reg) == (RW+1)'(h_eff) - (RW+1)'(3))
               && ((CW+1)'(out_col_reg) == (CW+1)'(w_eff) - (CW+1)'(3));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pix_in.ready = 1'b0;
        cfg.ready    = 1'b0;
        mom_start    = 1'b0;
        resp_start   = 1'b0;
        put          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pix_in.ready = 1'b1;
                cfg.ready    = !pix_in.valid;
                if (pix_in.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (anchor_ready)
                begin
                    mom_start  = 1'b1;
                    state_next = ST_MOM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOM:
            begin
                if (mom_done)
                begin
                    resp_start = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (resp_done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    put        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= RESET_WIDTH;
            height_cfg_reg <= RESET_HEIGHT;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (put)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_take)
            begin
                case (cfg.index)
                    CFG_IMAGE_WIDTH:
                    begin
                        width_cfg_reg <= cfg.data;
                        in_col_reg    <= '0;
                        in_row_reg    <= '0;
                        out_col_reg   <= '0;
                        out_row_reg   <= '0;
                    end
                    CFG_IMAGE_HEIGHT:
                    begin
                        height_cfg_reg <= cfg.data;
                        in_col_reg     <= '0;
                        in_row_reg     <= '0;
                        out_col_reg    <= '0;
                        out_row_reg    <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (pix_write)
            begin
                if (in_col_reg + CW'(1) >= w_eff)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            else if (put)
            begin
                if (last)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else if (out_col_reg + CW'(1) >= w_eff - CW'(2))
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_done)
        begin
            corner_res_reg <= resp_corner;
        end
        if (put)
        begin
            col_reg       <= COORD_W'(out_col_reg);
            row_reg       <= COORD_W'(out_row_reg);
            corner_reg    <= corner_res_reg;
            frame_end_reg <= last;
        end
    end

    hcf_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH)
    ) u_pixel_rows (
        .clk     (clk),
        .wr_en   (pix_write),
        .wr_addr ({in_row_reg[RING_BITS-1:0], in_col_reg[COLA-1:0]}),
        .wr_data (pix_in.pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hcf_moments #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_moments (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mom_start),
        .anchor_col (out_col_reg),
        .anchor_row (out_row_reg),
        .width      (w_eff),
        .height     (h_eff),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .done       (mom_done),
        .sums       (sums)
    );

    hcf_resp u_resp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (resp_start),
        .sums   (sums),
        .done   (resp_done),
        .corner (resp_corner)
    );

    assign res_out.valid     = out_valid_reg;
    assign res_out.col       = col_reg;
    assign res_out.row       = row_reg;
    assign res_out.corner    = corner_reg;
    assign res_out.frame_end = frame_end_reg;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for harris_corner_flag_stream: directed table, random frames, predictor.
module tb_top;
    import hcf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW      = 1024;
    localparam int MAXH      = 1024;
    localparam int IDLE_WAIT = 200;
    localparam int STALL_MAX = 5000;
    localparam int RANDOM_ITEMS = 900;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RSVD_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RSVD_B = 2'd3;

    typedef struct {
        bit [COORD_W-1:0] col;
        bit [COORD_W-1:0] row;
        bit               corner;
        bit               frame_end;
    } flag_t;

    typedef struct {
        bit                  is_cfg;
        bit [CFG_IDX_W-1:0]  idx;
        bit [CFG_DATA_W-1:0] data;
        bit                  req;
        bit [PIX_W-1:0]      px;
        bit                  typed;
        bit                  has;
        flag_t               f;
    } stim_row_t;

    logic clk;
    logic rst_n;
    hcf_in_if  pi();
    hcf_out_if ro();
    hcf_cfg_if cf();

    harris_corner_flag_stream uut (
        .clk(clk), .rst_n(rst_n), .pix_in(pi.sink), .res_out(ro.source), .cfg(cf.sink)
    );

    bit [7:0] line_ring[8][MAXW];
    int unsigned width_reg, height_reg;
    int unsigned in_col, in_row, out_col, out_row;
    flag_t flag_q[$];
    stim_row_t dir_rows[$];
    int errors;
    bit quiet;
    int stall_cnt;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
        if (v < 3) return 3;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int pix_at(int r, int c, int w, int h);
        if (r < 0 || c < 0 || r >= h || c >= w) return 0;
        return line_ring[r & 7][c];
    endfunction

    function automatic int shape(int v);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v > 127 ? v - 127 : 0;
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void apply_cfg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        if (idx == CFG_IMAGE_WIDTH)
        begin
            width_reg = data;
            restart_frame();
        end
        else if (idx == CFG_IMAGE_HEIGHT)
        begin
            height_reg = data;
            restart_frame();
        end
    endfunction

    function automatic bit flag_step(bit req, bit [PIX_W-1:0] px, output flag_t f);
        int unsigned w, h, nr, nc, y, x;
        longint sxx, sxy, syy, lhs, rhs;
        int r, c, gx, gy;
        bit last;
        w = clamp_size(width_reg, MAXW);
        h = clamp_size(height_reg, MAXH);
        y = out_row;
        x = out_col;
        sxx = 0;
        sxy = 0;
        syy = 0;
        f = '{0, 0, 0, 0};
        if (req == REQ_PIXEL && in_row < h)
        begin
            line_ring[in_row & 7][in_col] = px;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        end
        nr = (y + 3 < h - 1) ? y + 3 : h - 1;
        nc = (x + 3 < w - 1) ? x + 3 : w - 1;
        if (!(in_row >= h || nr < in_row || (nr == in_row && nc < in_col))) return 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                r = y + i;
                c = x + j;
                gx = shape((pix_at(r-1, c+1, w, h) - pix_at(r-1, c-1, w, h))
                     + 2 * (pix_at(r, c+1, w, h) - pix_at(r, c-1, w, h))
                     + (pix_at(r+1, c+1, w, h) - pix_at(r+1, c-1, w, h)));
                gy = shape((pix_at(r-1, c-1, w, h) + 2 * pix_at(r-1, c, w, h)
                     + pix_at(r-1, c+1, w, h)) - (pix_at(r+1, c-1, w, h)
                     + 2 * pix_at(r+1, c, w, h) + pix_at(r+1, c+1, w, h)));
                sxx += gx * gx;
                sxy += gx * gy;
                syy += gy * gy;
            end
        lhs = 25 * sxx * syy;
        rhs = 25 * sxy * sxy + (sxx + syy) * (sxx + syy);
        last = (y == h - 3) && (x == w - 3);
        f.col = x[COORD_W-1:0];
        f.row = y[COORD_W-1:0];
        f.corner = lhs > rhs;
        f.frame_end = last;
        out_col++;
        if (out_col >= w - 2)
        begin
            out_col = 0;
            out_row++;
        end
        if (last) restart_frame();
        return 1;
    endfunction

    task automatic send_pixel(bit req, bit [PIX_W-1:0] px, bit typed = 0, bit has = 0,
                              flag_t tf = '{0, 0, 0, 0});
        int n;
        flag_t f;
        bit got;
        n = quiet ? 0 : $urandom_range(0, 18);
        repeat (n)
        begin
            @(negedge clk);
            pi.valid = 1'b0;
        end
        @(negedge clk);
        pi.valid = 1'b1;
        pi.req_type = req;
        pi.pixel = px;
        do @(posedge clk); while (!pi.ready);
        got = flag_step(req, px, f);
        if (typed)
        begin
            if (has) flag_q.push_back(tf);
        end
        else if (got)
            flag_q.push_back(f);
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        @(negedge clk);
        pi.valid = 1'b0;
        while (flag_q.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
        cf.valid = 1'b1;
        cf.index = idx;
        cf.data = data;
        do @(posedge clk); while (!cf.ready);
        apply_cfg(idx, data);
        @(negedge clk);
        cf.valid = 1'b0;
    endtask

    function automatic bit [PIX_W-1:0] rand_pixel(int style);
        case (style)
            0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1: return PIX_W'($urandom_range(0, 255));
            default: return $urandom_range(0, 3) == 0 ? 8'hFF : 8'h00;
        endcase
    endfunction

    task automatic run_frame(int npix, bit drain);
        int style;
        style = $urandom_range(0, 2);
        for (int k = 0; k < npix; k++)
        begin
            if ($urandom_range(0, 15) == 0) send_pixel(REQ_DRAIN, PIX_W'($urandom_range(0, 255)));
            send_pixel(REQ_PIXEL, rand_pixel(style));
        end
        if (drain)
            while (in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0)
                send_pixel($urandom_range(0, 2) == 0 ? REQ_PIXEL : REQ_DRAIN,
                           PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic add_cfg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        dir_rows.push_back('{1, idx, data, 0, 0, 0, 0, '{0, 0, 0, 0}});
    endtask

    task automatic add_item(bit req, bit [PIX_W-1:0] px, bit typed, bit has, flag_t f);
        dir_rows.push_back('{0, 0, 0, req, px, typed, has, f});
    endtask

    always @(posedge clk)
    begin
        flag_t e;
        if (ro.valid && ro.ready)
        begin
            if (flag_q.size() == 0)
            begin
                $error("result with nothing expected: col %0d row %0d", ro.col, ro.row);
                errors++;
            end
            else
            begin
                e = flag_q.pop_front();
                if (ro.col !== e.col)
                begin
                    $error("col expected %0d actual %0d", e.col, ro.col);
                    errors++;
                end
                if (ro.row !== e.row)
                begin
                    $error("row expected %0d actual %0d", e.row, ro.row);
                    errors++;
                end
                if (ro.corner !== e.corner)
                begin
                    $error("corner expected %0d actual %0d", e.corner, ro.corner);
                    errors++;
                end
                if (ro.frame_end !== e.frame_end)
                begin
                    $error("frame_end expected %0d actual %0d", e.frame_end, ro.frame_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pi.valid && pi.ready) || (ro.valid && ro.ready) || (cf.valid && cf.ready)
            || !rst_n)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_MAX)
        begin
            $display("harris_corner_flag_stream test failed");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    initial
    begin
        int n;
        ro.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 18);
            repeat (n)
            begin
                @(negedge clk);
                ro.ready = 1'b0;
            end
            @(negedge clk);
            ro.ready = 1'b1;
            do @(posedge clk); while (!(ro.valid && ro.ready));
        end
    end

    initial
    begin
        int w, h, sent;
        stim_row_t s;
        errors = 0;
        stall_cnt = 0;
        quiet = 0;
        pi.valid = 1'b0;
        pi.req_type = REQ_PIXEL;
        pi.pixel = '0;
        cf.valid = 1'b0;
        cf.index = CFG_IMAGE_WIDTH;
        cf.data = '0;
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < MAXW; c++)
                line_ring[r][c] = 8'h00;
        width_reg = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        restart_frame();
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_item(REQ_DRAIN, 8'hFF, 1, 0, '{0, 0, 0, 0});
        add_item(REQ_PIXEL, 8'h00, 0, 0, '{0, 0, 0, 0});
        add_cfg(CFG_IMAGE_WIDTH, 11'd0);
        add_cfg(CFG_IMAGE_HEIGHT, 11'd3);
        add_cfg(CFG_IDX_RSVD_B, 11'd5);
        for (int k = 0; k < 9; k++) add_item(REQ_PIXEL, 8'hFF, 0, 0, '{0, 0, 0, 0});
        add_cfg(CFG_IMAGE_WIDTH, 11'd4);
        add_cfg(CFG_IMAGE_HEIGHT, 11'd2);
        for (int k = 0; k < 11; k++) add_item(REQ_PIXEL, 8'h00, 0, 0, '{0, 0, 0, 0});
        add_item(REQ_PIXEL, 8'h00, 1, 1, '{0, 0, 0, 0});
        add_item(REQ_PIXEL, 8'hA5, 1, 1, '{1, 0, 0, 1});
        foreach (dir_rows[i])
        begin
            s = dir_rows[i];
            if (s.is_cfg) write_reg(s.idx, s.data);
            else send_pixel(s.req, s.px, s.typed, s.has, s.f);
        end

        quiet = 1;
        write_reg(CFG_IMAGE_WIDTH, 11'd2047);
        write_reg(CFG_IMAGE_HEIGHT, 11'd3);
        run_frame(700, 0);
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        write_reg(CFG_IMAGE_HEIGHT, 11'd1024);
        run_frame(300, 0);
        write_reg(CFG_IMAGE_HEIGHT, 11'd5);
        quiet = 0;

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
                write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            end
            else
            begin
                w = clamp_size(width_reg, MAXW);
                h = clamp_size(height_reg, MAXH);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                n_partial(w, h, sent);
            end
            else
            begin
                run_frame(w * h, 1);
                sent += w * h;
            end
        end
        quiet = 0;

        @(negedge clk);
        pi.valid = 1'b0;
        while (flag_q.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        if (errors == 0)
            $display("harris_corner_flag_stream test passed");
        else
            $display("harris_corner_flag_stream test failed");
        $finish;
    end

    task automatic n_partial(int w, int h, inout int sent);
        int cnt;
        cnt = $urandom_range(1, w * h);
        run_frame(cnt, 0);
        sent += cnt;
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_IDX_RSVD_A, CFG_DATA_W'($urandom_range(0, 2047)));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(clamp_size(width_reg, MAXW)));
    endtask
endmodule

/* filelist.f */
rtl/core/hcf_pkg.sv
rtl/core/hcf_if.sv
rtl/core/hcf_ram.sv
rtl/core/hcf_moments.sv
rtl/core/hcf_resp.sv
rtl/core/harris_corner_flag_stream.sv
bench/tb_top.sv
